### rtl/ede_pkg.sv
// ----------------------------------------------------------------------------
// ede_pkg: shared types and helpers of the edit distance engine
// Item formats, the token that travels along the cell chain, and the
// saturating arithmetic that every cell uses.
// ----------------------------------------------------------------------------
`default_nettype none

package ede_pkg;

  localparam int unsigned DefMaxLen = 64;
  localparam int unsigned DistW     = 16;
  localparam int unsigned IdxW      = 10;  // cell index, enough for 1024 cells
  localparam int unsigned LenW      = 11;  // string length 0..1024

  localparam logic [DistW-1:0] DistMax = '1;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_STEP   = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] ch;
  } in_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             overflow;
  } out_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_STEP   = 2'd2,
    OP_REPORT = 2'd3
  } op_t;

  // One token per accepted item; it visits every cell in order.
  typedef struct packed {
    op_t              op;
    logic [7:0]       ch;
    logic [IdxW-1:0]  idx;
    logic [DistW-1:0] up;
    logic [DistW-1:0] diag;
    logic             ovf;
  } tok_t;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [DistW-1:0] count;
    logic             ovf;
  } head_stat_t;

  function automatic logic [DistW-1:0] sat_inc(input logic [DistW-1:0] v);
    return (v == DistMax) ? DistMax : v + 1'b1;
  endfunction

  function automatic logic [DistW-1:0] min2(input logic [DistW-1:0] a,
                                            input logic [DistW-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### rtl/edit_distance_engine_core.sv
// ----------------------------------------------------------------------------
// edit_distance_engine_core: Levenshtein distance of two byte strings
// A head stage feeds a chain of MAX_LEN cells, one per first-string byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input items carry func and ch. func 0 appends ch to the first string,
//   func 1 feeds ch as the next byte of the second string, func 2 asks for
//   the distance and clears both strings. Only func 2 gives an output item
//   (distance, overflow flag).
//   Every item becomes a token that walks the cell chain one cell per cycle
//   while the chain is not held, so one item is taken per clock in steady
//   state, any mix of functions. A report passes the head register, each
//   cell and the output register. Bytes of the first string beyond MAX_LEN
//   are dropped and set the overflow flag until the next report.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and in_ready drops in the same cycle; nothing is lost.
//   Reset clears the strings, the counts and the chain; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance_engine_core #(
  parameter int unsigned MAX_LEN = ede_pkg::DefMaxLen
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ede_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ede_pkg::out_t      out_data
);
  import ede_pkg::*;

  logic       adv;
  logic       take;
  tok_t       chain [MAX_LEN+1];
  head_stat_t stat;
  logic       tail_rep;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign take     = in_valid && adv;

  ede_head #(.MAX_LEN(MAX_LEN)) u_head (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .take (take),
    .item (in_data),
    .tok  (chain[0]),
    .stat (stat)
  );

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    ede_cell #(.INDEX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign tail_rep = (chain[MAX_LEN].op == OP_REPORT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tail_rep;
      if (tail_rep) begin
        out_data.distance <= chain[MAX_LEN].up;
        out_data.overflow <= chain[MAX_LEN].ovf;
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    stat.len <= LenW'(MAX_LEN))
    else $error("first string length beyond MAX_LEN");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    take && (in_data.func == FUNC_REPORT) |=>
      (stat.len == '0) && (stat.count == '0) && !stat.ovf)
    else $error("report did not clear the head state");

  a_tail_emits: assert property (@(posedge clk) disable iff (rst)
    adv && tail_rep |=> out_valid)
    else $error("report token left the chain without a result");

endmodule

`default_nettype wire

### rtl/ede_head.sv
// ----------------------------------------------------------------------------
// ede_head: front of the cell chain
// Holds the string length, the second-string count (column entry zero) and
// the overflow flag, and turns each accepted item into a chain token.
// ----------------------------------------------------------------------------
`default_nettype none

module ede_head #(
  parameter int unsigned MAX_LEN = ede_pkg::DefMaxLen
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               take,
  input  wire ede_pkg::in_t       item,
  output ede_pkg::tok_t           tok,
  output ede_pkg::head_stat_t     stat
);
  import ede_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic [LW-1:0]    len;
  logic [DistW-1:0] count;
  logic             ovf;
  logic [DistW-1:0] count_inc;

  assign count_inc = sat_inc(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      len    <= '0;
      count  <= '0;
      ovf    <= 1'b0;
      tok.op <= OP_NONE;
    end else if (adv) begin
      tok.op   <= OP_NONE;
      tok.ch   <= item.ch;
      tok.idx  <= IdxW'(len);
      tok.up   <= count_inc;
      tok.diag <= count;
      tok.ovf  <= ovf;
      if (take) begin
        unique case (item.func)
          FUNC_APPEND: begin
            // Appends are ignored once the second string has started.
            if (count == '0) begin
              if (len < LW'(MAX_LEN)) begin
                tok.op <= OP_LOAD;
                len    <= len + 1'b1;
              end else begin
                ovf <= 1'b1;
              end
            end
          end
          FUNC_STEP: begin
            tok.op <= OP_STEP;
            count  <= count_inc;
          end
          FUNC_REPORT: begin
            tok.op <= OP_REPORT;
            tok.up <= count;
            len    <= '0;
            count  <= '0;
            ovf    <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign stat.len   = LenW'(len);
  assign stat.count = count;
  assign stat.ovf   = ovf;

endmodule

`default_nettype wire

### rtl/ede_cell.sv
// ----------------------------------------------------------------------------
// ede_cell: one cell of the distance chain
// Holds one byte of the first string and its entry of the distance column,
// updates that entry for each second-string byte and passes the token on.
// ----------------------------------------------------------------------------
`default_nettype none

module ede_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire ede_pkg::tok_t tok_in,
  output ede_pkg::tok_t      tok_out
);
  import ede_pkg::*;

  localparam logic [DistW-1:0] DInit = DistW'(INDEX + 1);

  logic             loaded;
  logic [7:0]       c;
  logic [DistW-1:0] d;
  logic [DistW-1:0] diag_cost;
  logic [DistW-1:0] best;

  assign diag_cost = (c == tok_in.ch) ? tok_in.diag : sat_inc(tok_in.diag);
  assign best      = min2(min2(sat_inc(d), sat_inc(tok_in.up)), diag_cost);

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded     <= 1'b0;
      d          <= DInit;
      tok_out.op <= OP_NONE;
    end else if (adv) begin
      tok_out <= tok_in;
      unique case (tok_in.op)
        OP_LOAD: begin
          if (tok_in.idx == IdxW'(INDEX)) begin
            c      <= tok_in.ch;
            loaded <= 1'b1;
          end
        end
        OP_STEP: begin
          if (loaded) begin
            d            <= best;
            tok_out.up   <= best;
            tok_out.diag <= d;
          end
        end
        OP_REPORT: begin
          // The last loaded cell leaves its entry in the up lane.
          if (loaded) tok_out.up <= d;
          loaded <= 1'b0;
          d      <= DInit;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for edit_distance_engine_core
// Feeds first-string, second-string and report items and predicts each
// reported distance with a behavioral copy of the column update. Results are
// compared field by field. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb;
  import ede_pkg::*;

  localparam int unsigned DEPTH = DefMaxLen;
  localparam int unsigned LIMIT = 500000;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int cycle_count = 0;
  int items_taken = 0;
  int reports_checked = 0;

  // Behavioral copy of the engine state.
  logic [7:0] stored_bytes [DEPTH];
  int unsigned stored_len;
  logic [DistW-1:0] dist_col [DEPTH+1];
  logic [DistW-1:0] steps_seen;
  logic trunc_flag;
  out_t expected_reports [$];

  edit_distance_engine_core #(.MAX_LEN(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  function automatic logic [DistW-1:0] plus_one(input logic [DistW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_pair();
    for (int y = 0; y <= DEPTH; y++) dist_col[y] = DistW'(y);
    stored_len = 0;
    steps_seen = '0;
    trunc_flag = 1'b0;
  endfunction

  function automatic void update_distances(input in_t it);
    logic [DistW-1:0] diag, old, best, cand;
    case (it.func)
      FUNC_APPEND: begin
        // Appends are dropped once the second string has started.
        if (steps_seen == 0) begin
          if (stored_len < DEPTH) begin
            stored_bytes[stored_len] = it.ch;
            stored_len++;
          end else begin
            trunc_flag = 1'b1;
          end
        end
      end
      FUNC_STEP: begin
        diag = dist_col[0];
        dist_col[0] = plus_one(diag);
        steps_seen = dist_col[0];
        for (int y = 1; y <= stored_len; y++) begin
          old = dist_col[y];
          best = plus_one(old);
          cand = plus_one(dist_col[y-1]);
          if (cand < best) best = cand;
          cand = (stored_bytes[y-1] == it.ch) ? diag : plus_one(diag);
          if (cand < best) best = cand;
          dist_col[y] = best;
          diag = old;
        end
      end
      FUNC_REPORT: begin
        expected_reports.push_back('{distance: dist_col[stored_len], overflow: trunc_flag});
        clear_pair();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      update_distances(in_data);
      items_taken++;
    end
  end

  always @(posedge clk) begin
    out_t exp_item;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report distance=%0d overflow=%0b",
                 $time, out_data.distance, out_data.overflow);
      end else begin
        exp_item = expected_reports.pop_front();
        reports_checked++;
        if (out_data.distance !== exp_item.distance) begin
          errors++;
          $display("%0t: distance expected %0d actual %0d",
                   $time, exp_item.distance, out_data.distance);
        end
        if (out_data.overflow !== exp_item.overflow) begin
          errors++;
          $display("%0t: overflow expected %0b actual %0b",
                   $time, exp_item.overflow, out_data.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL edit_distance_engine_core");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] f, input logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{func: f, ch: c};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender until every report has come back and the chain is empty.
  task automatic wait_all_reported();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(input bit narrow);
    return narrow ? 8'h61 + 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
  endfunction

  task automatic test_empty_strings();
    send_item(FUNC_REPORT, 8'h00);
    send_item(FUNC_APPEND, 8'h00);
    send_item(FUNC_APPEND, 8'hFF);
    send_item(FUNC_REPORT, 8'h00);
    send_item(FUNC_STEP, 8'hFF);
    send_item(FUNC_STEP, 8'h00);
    send_item(FUNC_STEP, 8'h55);
    send_item(FUNC_REPORT, 8'hAA);
  endtask

  task automatic test_ignored_items();
    send_item(FUNC_SPARE, 8'hFF);
    send_item(FUNC_APPEND, 8'h41);
    send_item(FUNC_STEP, 8'h41);
    send_item(FUNC_APPEND, 8'h42);
    send_item(FUNC_SPARE, 8'h00);
    send_item(FUNC_REPORT, 8'hFF);
  endtask

  task automatic test_known_pair();
    logic [7:0] a [4] = '{8'h66, 8'h6C, 8'h61, 8'h77};
    logic [7:0] b [4] = '{8'h6C, 8'h61, 8'h77, 8'h6E};
    foreach (a[i]) send_item(FUNC_APPEND, a[i]);
    foreach (b[i]) send_item(FUNC_STEP, b[i]);
    send_item(FUNC_REPORT, 8'h00);
  endtask

  task automatic test_first_string_full();
    for (int i = 0; i < DEPTH + 3; i++) send_item(FUNC_APPEND, pick_byte(i[0]));
    for (int i = 0; i < 5; i++) send_item(FUNC_STEP, pick_byte(1'b1));
    send_item(FUNC_REPORT, 8'h00);
    // The overflow flag must not survive the report.
    send_item(FUNC_REPORT, 8'h00);
    for (int i = 0; i < DEPTH; i++) send_item(FUNC_APPEND, pick_byte(1'b0));
    for (int i = 0; i < DEPTH + 2; i++) send_item(FUNC_STEP, pick_byte(1'b0));
    send_item(FUNC_REPORT, 8'h00);
  endtask

  task automatic test_long_second_string();
    send_item(FUNC_APPEND, 8'h61);
    send_item(FUNC_APPEND, 8'h62);
    for (int i = 0; i < 90; i++) send_item(FUNC_STEP, pick_byte(1'b1));
    send_item(FUNC_APPEND, 8'h63);
    send_item(FUNC_REPORT, 8'h00);
    for (int i = 0; i < 100; i++) send_item(FUNC_STEP, 8'h00);
    send_item(FUNC_REPORT, 8'h00);
  endtask

  task automatic test_random_pairs(input int idle, input int stall, input int quota);
    int sent;
    int len;
    int steps;
    bit narrow;
    bit in_second;
    logic [1:0] f;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    in_second = 1'b0;
    while (sent < quota) begin
      if ($urandom_range(99) < 85) begin
        narrow = $urandom_range(0, 3) != 0;
        len = ($urandom_range(9) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 4)
                                       : $urandom_range(0, 10);
        steps = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
        if (!in_second) begin
          for (int i = 0; i < len; i++) send_item(FUNC_APPEND, pick_byte(narrow));
          sent += len;
        end
        for (int i = 0; i < steps; i++) begin
          send_item(FUNC_STEP, pick_byte(narrow));
          if ($urandom_range(19) == 0) send_item(FUNC_APPEND, pick_byte(narrow));
          if ($urandom_range(29) == 0) send_item(FUNC_SPARE, pick_byte(1'b0));
        end
        sent += steps;
        send_item(FUNC_REPORT, pick_byte(1'b0));
        sent++;
        in_second = 1'b0;
      end else begin
        // Broken sequences: stray functions in any order.
        repeat ($urandom_range(1, 4)) begin
          f = 2'($urandom_range(0, 3));
          send_item(f, pick_byte(1'b0));
          if (f == FUNC_STEP) in_second = 1'b1;
          if (f == FUNC_REPORT) in_second = 1'b0;
          if (f == FUNC_STEP || f == FUNC_REPORT || (f == FUNC_APPEND && !in_second)) sent++;
        end
      end
    end
    wait_all_reported();
  endtask

  initial begin
    clear_pair();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_strings();
    test_ignored_items();
    test_known_pair();
    wait_all_reported();
    test_first_string_full();
    wait_all_reported();
    test_long_second_string();
    wait_all_reported();
    test_random_pairs(0, 0, 330);
    test_random_pairs(57, 0, 330);
    test_random_pairs(0, 57, 330);
    test_random_pairs(29, 29, 330);
    $display("Ran %0d items through the engine and checked %0d distance reports,",
             items_taken, reports_checked);
    $display("with full and overflowing first strings and long second strings.");
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("PASS edit_distance_engine_core");
    end else begin
      $display("FAIL edit_distance_engine_core");
    end
    $finish;
  end

endmodule

### edit_distance_engine_core.f
rtl/ede_pkg.sv
rtl/ede_head.sv
rtl/ede_cell.sv
rtl/edit_distance_engine_core.sv
tb/tb.sv
